// File: sv/gds_pkg.sv
// Shared types, codes and calendar helpers for the date subtractor.
// No dependencies; used by every file under sv/.
`default_nettype none
package gds_pkg;

   // Width of the shared add/subtract unit (holds year*12+11)
   localparam int AluW = 17;

   // Request kinds
   localparam logic [1:0] KindDays   = 2'd0;
   localparam logic [1:0] KindMonths = 2'd1;
   localparam logic [1:0] KindYears  = 2'd2;

   // Result status codes
   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StUnder   = 2'd1;
   localparam logic [1:0] StInvalid = 2'd2;

   localparam logic [13:0] YearMax = 14'd9999;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] amount;
      logic [13:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
   } req_type;

   typedef struct packed {
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [1:0]  status;
   } rsp_type;

   // Shared unit control and flags
   typedef struct packed {
      logic sub;
   } alu_ctl_type;

   typedef struct packed {
      logic ge;     // a >= b on a subtract
      logic zero;   // result is zero
   } alu_flags_type;

   localparam logic [4:0] MonthLen [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Length of a month; zero for a month code outside 1..12
   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      len = 5'd0;
      if (month == 4'd2) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (month >= 4'd1 && month <= 4'd12) begin
         len = MonthLen[month - 4'd1];
      end
      return len;
   endfunction

endpackage
`default_nettype wire

// File: sv/gregorian_date_subtract.sv
// Gregorian date subtractor: days, months or years back from a date.
// It first finds the year's place in the 400-year cycle; day mode then adds two month walks
// and takes whole years back one at a time, while month and year modes find the place of
// the result year again before they finish. One word at a time; busy falls with the strobe.
// Synchronous active-high reset returns the sequencer to idle with no strobe pending.
`default_nettype none
module gregorian_date_subtract (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gds_pkg::req_type req_data,
   output logic             rsp_valid,
   output gds_pkg::rsp_type rsp_data
);
   import gds_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_M400, S_M100, S_CHECK, S_DOY, S_YEARS, S_SUBAMT, S_FIND,
      S_MUL_A, S_MUL_B, S_SUB12, S_CMPAMT, S_DIV, S_DIVEND, S_YRSUB, S_ADJUST
   } state_type;

   state_type      state_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   logic [1:0]     kind_ff;
   logic [15:0]    amt_ff;
   logic [13:0]    yin_ff;
   logic [3:0]     min_ff;
   logic [4:0]     din_ff;
   logic [13:0]    yr_ff;
   logic [AluW-1:0] acc_ff;
   logic [3:0]     rem_ff;
   logic [8:0]     m400_ff;
   logic [6:0]     m100_ff;
   logic [3:0]     mi_ff;
   logic           pass2_ff;

   alu_ctl_type     alu_ctl;
   logic [AluW-1:0] alu_a;
   logic [AluW-1:0] alu_b;
   logic [AluW-1:0] alu_res;
   alu_flags_type   alu_flags;

   logic       leap;
   logic       leap_next;
   logic [8:0] m400_in;
   logic [6:0] m100_in;
   logic [13:0] yr_in;
   logic [4:0] dim_mi;
   logic [4:0] dim_in;
   logic       date_ok;
   logic [30:0] div_prod;
   logic [13:0] div_q;
   logic [3:0] rem_in;
   logic [4:0] adj_day;

   gds_alu u_alu (
      .ctl    (alu_ctl),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_res),
      .flags  (alu_flags)
   );

   // Leap flag of the working year from its residues mod 400 and mod 100
   assign leap = (m400_ff == 9'd0) || ((m100_ff != 7'd0) && (yr_ff[1:0] == 2'b00));

   // Step the residues one year back
   assign yr_in   = yr_ff - 14'd1;
   assign m400_in = (m400_ff == 9'd0) ? 9'd399 : m400_ff - 9'd1;
   assign m100_in = (m100_ff == 7'd0) ? 7'd99 : m100_ff - 7'd1;
   assign leap_next = (m400_in == 9'd0) || ((m100_in != 7'd0) && (yr_in[1:0] == 2'b00));

   assign dim_mi = days_in_month(mi_ff, leap);
   assign dim_in = days_in_month(min_ff, leap);

   // Divide by twelve: quarter the index, then multiply by the reciprocal of three
   assign div_prod = {16'd0, acc_ff[AluW-1:2]} * 31'd43691;
   assign div_q    = div_prod[30:17];
   // Remainder from the low bits only, since it is below twelve
   assign rem_in   = acc_ff[3:0] - ({div_q[0], 3'b000} + {div_q[1:0], 2'b00});

   assign date_ok = (yin_ff != 14'd0) && (yin_ff <= YearMax) &&
                    (min_ff != 4'd0) && (min_ff <= 4'd12) &&
                    (din_ff != 5'd0) && (din_ff <= dim_in);

   // Clamp for month mode, Feb 29 fixup for year mode
   always_comb begin
      adj_day = din_ff;
      if (kind_ff == KindMonths) begin
         if (din_ff > dim_mi) begin
            adj_day = dim_mi;
         end
      end else if (min_ff == 4'd2 && din_ff == 5'd29 && !leap) begin
         adj_day = 5'd28;
      end
   end

   // Operand select for the shared unit
   always_comb begin
      alu_ctl.sub = 1'b1;
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         S_M400: begin
            alu_a = acc_ff;
            alu_b = AluW'(400);
         end
         S_M100: begin
            alu_a = acc_ff;
            alu_b = AluW'(100);
         end
         S_DOY: begin
            alu_ctl.sub = 1'b0;
            alu_a = acc_ff;
            alu_b = {{(AluW-5){1'b0}}, dim_mi};
         end
         S_YEARS: begin
            alu_a = {{(AluW-16){1'b0}}, amt_ff};
            alu_b = acc_ff;
         end
         S_SUBAMT, S_CMPAMT: begin
            alu_a = acc_ff;
            alu_b = {{(AluW-16){1'b0}}, amt_ff};
         end
         S_FIND: begin
            alu_a = acc_ff;
            alu_b = {{(AluW-5){1'b0}}, dim_mi};
         end
         S_MUL_A: begin
            alu_ctl.sub = 1'b0;
            alu_a = {yin_ff, 3'b000};
            alu_b = {1'b0, yin_ff, 2'b00};
         end
         S_MUL_B: begin
            alu_ctl.sub = 1'b0;
            alu_a = acc_ff;
            alu_b = {{(AluW-4){1'b0}}, min_ff - 4'd1};
         end
         S_SUB12: begin
            alu_a = acc_ff;
            alu_b = AluW'(12);
         end
         S_DIVEND: begin
            alu_ctl.sub = 1'b0;
            alu_a = acc_ff;
            alu_b = AluW'(1);
         end
         S_YRSUB: begin
            alu_a = {3'b000, yin_ff};
            alu_b = {{(AluW-16){1'b0}}, amt_ff};
         end
         default: begin
            alu_ctl.sub = 1'b1;
         end
      endcase
   end

   // Sequencer, working registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff  <= req_data.kind;
                  amt_ff   <= req_data.amount;
                  yin_ff   <= req_data.year_in;
                  min_ff   <= req_data.month_in;
                  din_ff   <= req_data.day_in;
                  yr_ff    <= req_data.year_in;
                  acc_ff   <= {3'b000, req_data.year_in};
                  pass2_ff <= 1'b0;
                  state_ff <= S_M400;
               end
            end
            S_M400: begin
               if (alu_flags.ge) begin
                  acc_ff <= alu_res;
               end else begin
                  m400_ff  <= acc_ff[8:0];
                  state_ff <= S_M100;
               end
            end
            S_M100: begin
               if (alu_flags.ge) begin
                  acc_ff <= alu_res;
               end else begin
                  m100_ff  <= acc_ff[6:0];
                  state_ff <= pass2_ff ? S_ADJUST : S_CHECK;
               end
            end
            S_CHECK: begin
               if (!date_ok) begin
                  rsp_ff       <= '{yin_ff, min_ff, din_ff, StInvalid};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  case (kind_ff)
                     KindDays: begin
                        if (amt_ff == 16'd0) begin
                           rsp_ff       <= '{yin_ff, min_ff, din_ff, StOk};
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_IDLE;
                        end else begin
                           acc_ff   <= {{(AluW-5){1'b0}}, din_ff};
                           mi_ff    <= 4'd1;
                           state_ff <= S_DOY;
                        end
                     end
                     KindMonths: begin
                        state_ff <= S_MUL_A;
                     end
                     KindYears: begin
                        state_ff <= S_YRSUB;
                     end
                     default: begin
                        rsp_ff       <= '{yin_ff, min_ff, din_ff, StOk};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  endcase
               end
            end
            // Day of year: add lengths of the months before the start month
            S_DOY: begin
               if (mi_ff < min_ff) begin
                  acc_ff <= alu_res;
                  mi_ff  <= mi_ff + 4'd1;
               end else begin
                  state_ff <= S_YEARS;
               end
            end
            // Take whole years back while the remainder reaches past them
            S_YEARS: begin
               if (alu_flags.ge) begin
                  amt_ff <= alu_res[15:0];
                  if (yr_ff == 14'd1) begin
                     rsp_ff       <= '{yin_ff, min_ff, din_ff, StUnder};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     yr_ff   <= yr_in;
                     m400_ff <= m400_in;
                     m100_ff <= m100_in;
                     acc_ff  <= leap_next ? AluW'(366) : AluW'(365);
                  end
               end else begin
                  state_ff <= S_SUBAMT;
               end
            end
            S_SUBAMT: begin
               acc_ff   <= alu_res;
               mi_ff    <= 4'd1;
               state_ff <= S_FIND;
            end
            // Walk months of the final year until the day fits
            S_FIND: begin
               if (mi_ff < 4'd12 && alu_flags.ge && !alu_flags.zero) begin
                  acc_ff <= alu_res;
                  mi_ff  <= mi_ff + 4'd1;
               end else begin
                  rsp_ff       <= '{yr_ff, mi_ff, acc_ff[4:0], StOk};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            // Month index: year*12 + month-1, less twelve, less the amount
            S_MUL_A: begin
               acc_ff   <= alu_res;
               state_ff <= S_MUL_B;
            end
            S_MUL_B: begin
               acc_ff   <= alu_res;
               state_ff <= S_SUB12;
            end
            S_SUB12: begin
               acc_ff   <= alu_res;
               state_ff <= S_CMPAMT;
            end
            S_CMPAMT: begin
               if (!alu_flags.ge) begin
                  rsp_ff       <= '{yin_ff, min_ff, din_ff, StUnder};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  acc_ff   <= alu_res;
                  state_ff <= S_DIV;
               end
            end
            // Load quotient into acc and hold the remainder
            S_DIV: begin
               acc_ff   <= {3'b000, div_q};
               rem_ff   <= rem_in;
               state_ff <= S_DIVEND;
            end
            // Year is quotient plus one, the twelve taken off earlier
            S_DIVEND: begin
               acc_ff   <= alu_res;
               yr_ff    <= alu_res[13:0];
               mi_ff    <= rem_ff + 4'd1;
               pass2_ff <= 1'b1;
               state_ff <= S_M400;
            end
            S_YRSUB: begin
               if (!alu_flags.ge || alu_flags.zero) begin
                  rsp_ff       <= '{yin_ff, min_ff, din_ff, StUnder};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  acc_ff   <= alu_res;
                  yr_ff    <= alu_res[13:0];
                  mi_ff    <= min_ff;
                  pass2_ff <= 1'b1;
                  state_ff <= S_M400;
               end
            end
            S_ADJUST: begin
               rsp_ff       <= '{yr_ff, mi_ff, adj_day, StOk};
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: sv/gds_alu.sv
// Shared add/subtract and compare unit of the date subtractor.
// Depends on gds_pkg for widths and control types.
`default_nettype none
module gds_alu (
   input  gds_pkg::alu_ctl_type      ctl,
   input  logic [gds_pkg::AluW-1:0]  a,
   input  logic [gds_pkg::AluW-1:0]  b,
   output logic [gds_pkg::AluW-1:0]  result,
   output gds_pkg::alu_flags_type    flags
);
   import gds_pkg::*;

   logic [AluW:0] sum;

   // Add, or add the complement plus one; carry out means no borrow
   assign sum = {1'b0, a} + {1'b0, (ctl.sub ? ~b : b)} + {{AluW{1'b0}}, ctl.sub};
   assign result = sum[AluW-1:0];
   assign flags.ge = sum[AluW];
   assign flags.zero = (sum[AluW-1:0] == '0);

endmodule
`default_nettype wire

// File: sv/gds_checker.sv
// Port-level checks for the date subtractor, bound to the top level.
// Depends on gds_pkg and on the gregorian_date_subtract ports.
`default_nettype none
module gds_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input gds_pkg::rsp_type rsp_data
);
   import gds_pkg::*;

   // Accepted word always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // Strobe lasts one cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Work ends only with a result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Result of a valid date carries a real month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != StInvalid |->
         rsp_data.month_out >= 4'd1 && rsp_data.month_out <= 4'd12 &&
         rsp_data.status != 2'd3)
      else $error("result month out of range");

endmodule

bind gregorian_date_subtract gds_checker u_gds_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: bench/date_shift_checker.sv
`timescale 1ns / 1ps
// Result checker for gregorian_date_subtract: watches request and result words,
// predicts each result date and compares it field by field. Depends on gds_pkg.
module date_shift_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  gds_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  gds_pkg::rsp_type rsp_data,
   input  logic             finish_check,
   output int unsigned      fail_count,
   output int unsigned      pending,
   output int unsigned      words_seen,
   output int unsigned      results_seen
);
   import gds_pkg::*;

   // Print only the first mismatches; count all of them
   localparam int unsigned PrintLimit = 30;

   typedef struct {
      req_type ask;
      rsp_type want;
   } date_job_type;

   date_job_type open_jobs[$];
   int unsigned  mismatches = 0;
   int unsigned  job_count = 0;
   int unsigned  strobe_count = 0;
   int unsigned  queued = 0;
   bit           leftover_flagged = 1'b0;

   assign fail_count   = mismatches;
   assign pending      = queued;
   assign words_seen   = job_count;
   assign results_seen = strobe_count;

   function automatic bit is_leap(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   // Zero for a month code outside 1..12
   function automatic int unsigned month_days(input int unsigned yr, input int unsigned mo);
      int unsigned len;
      case (mo)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = is_leap(yr) ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   // Move the requested date back by days, months or years
   function automatic rsp_type shift_date_back(input req_type w);
      rsp_type     r;
      int unsigned yr, mo, dy, left, doy, total, cap, i;
      bit          under;
      yr          = w.year_in;
      mo          = w.month_in;
      dy          = w.day_in;
      left        = w.amount;
      r.year_out  = w.year_in;
      r.month_out = w.month_in;
      r.day_out   = w.day_in;
      r.status    = StOk;
      under       = 1'b0;
      if (yr < 1 || yr > YearMax || mo < 1 || mo > 12 || dy < 1 ||
          dy > month_days(yr, mo)) begin
         r.status = StInvalid;
      end else if (w.kind == KindDays && left != 0) begin
         // day of year, then strip whole years while the amount covers them
         doy = dy;
         for (i = 1; i < mo; i++) doy += month_days(yr, i);
         while (!under && doy <= left) begin
            left -= doy;
            yr--;
            if (yr == 0) under = 1'b1;
            else doy = is_leap(yr) ? 366 : 365;
         end
         if (under) begin
            r.status = StUnder;
         end else begin
            doy -= left;
            mo = 1;
            while (mo < 12 && doy > month_days(yr, mo)) begin
               doy -= month_days(yr, mo);
               mo++;
            end
            r.year_out  = yr[13:0];
            r.month_out = mo[3:0];
            r.day_out   = doy[4:0];
         end
      end else if (w.kind == KindMonths) begin
         total = yr * 12 + (mo - 1);
         if (total < left + 12) begin
            r.status = StUnder;
         end else begin
            total      -= left;
            yr          = total / 12;
            mo          = total % 12 + 1;
            cap         = month_days(yr, mo);
            r.year_out  = yr[13:0];
            r.month_out = mo[3:0];
            r.day_out   = (dy > cap) ? cap[4:0] : dy[4:0];
         end
      end else if (w.kind == KindYears) begin
         if (left >= yr) begin
            r.status = StUnder;
         end else begin
            yr         = yr - left;
            r.year_out = yr[13:0];
            if (mo == 2 && dy == 29 && !is_leap(yr)) r.day_out = 5'd28;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PrintLimit) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Compare each strobed result with the oldest open job, then queue new requests
   always @(posedge clock) begin
      date_job_type job;
      rsp_type      got;
      string        tag;
      if (!reset) begin
         if (rsp_valid) begin
            strobe_count++;
            got = rsp_data;
            if (open_jobs.size() == 0) begin
               report_mismatch($sformatf("result word %0d-%0d-%0d st %0d with none expected",
                  got.year_out, got.month_out, got.day_out, got.status));
            end else begin
               job = open_jobs.pop_front();
               tag = $sformatf("kind %0d amount %0d from %0d-%0d-%0d:", job.ask.kind,
                  job.ask.amount, job.ask.year_in, job.ask.month_in, job.ask.day_in);
               if (got.year_out !== job.want.year_out)
                  report_mismatch($sformatf("%s year %0d, expected %0d", tag,
                     got.year_out, job.want.year_out));
               if (got.month_out !== job.want.month_out)
                  report_mismatch($sformatf("%s month %0d, expected %0d", tag,
                     got.month_out, job.want.month_out));
               if (got.day_out !== job.want.day_out)
                  report_mismatch($sformatf("%s day %0d, expected %0d", tag,
                     got.day_out, job.want.day_out));
               if (got.status !== job.want.status)
                  report_mismatch($sformatf("%s status %0d, expected %0d", tag,
                     got.status, job.want.status));
            end
         end
         if (start && !busy) begin
            job.ask  = req_data;
            job.want = shift_date_back(req_data);
            open_jobs.push_back(job);
            job_count++;
         end
      end
      queued = open_jobs.size();
      // flag words that never came back, once
      if (finish_check && !leftover_flagged) begin
         leftover_flagged = 1'b1;
         if (open_jobs.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", open_jobs.size()));
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the date subtractor bench: clock, reset and request stimulus, the
// block and its result checker side by side. Depends on gds_pkg.
module testbench;
   import gds_pkg::*;

   localparam logic [1:0]  KindUnused  = 2'd3;
   localparam int unsigned PhaseWords  = 200;
   localparam int unsigned DrainLimit  = 2000;
   localparam int unsigned TailCycles  = 320;
   localparam int unsigned IdlePct [4] = '{0, 60, 0, 19};

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        finish_check = 1'b0;
   req_type     req_data = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   int unsigned fail_count, pending, words_seen, results_seen;

   gregorian_date_subtract dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   date_shift_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .finish_check (finish_check),
      .fail_count   (fail_count),
      .pending      (pending),
      .words_seen   (words_seen),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #25ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic req_type pack_request(input logic [1:0] kind, input int unsigned amount,
                                            input int unsigned yr, input int unsigned mo,
                                            input int unsigned dy);
      req_type w;
      w.kind     = kind;
      w.amount   = amount[15:0];
      w.year_in  = yr[13:0];
      w.month_in = mo[3:0];
      w.day_in   = dy[4:0];
      return w;
   endfunction

   function automatic int unsigned days_of(input int unsigned yr, input int unsigned mo);
      int unsigned len;
      case (mo)
         4, 6, 9, 11: len = 30;
         2:           len = ((yr % 400 == 0) || (yr % 100 != 0 && yr % 4 == 0)) ? 29 : 28;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // Mostly valid dates with random content; some noise and bad dates
   function automatic req_type random_request();
      req_type                  w;
      logic [63:0]              raw;
      logic [$bits(req_type)-1:0] bits;
      logic [1:0]               kind;
      int unsigned              yr, mo, dy, cap, amount, mult;
      if ($urandom_range(0, 99) < 8) begin
         raw  = {$urandom(), $urandom()};
         bits = raw[$bits(req_type)-1:0];
         w    = bits;
      end else begin
         kind = ($urandom_range(0, 19) == 0) ? KindUnused : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0, 1:    yr = $urandom_range(1, 120);
            2:       yr = $urandom_range(1, 99) * 100;
            3:       yr = $urandom_range(1, 2499) * 4;
            default: yr = $urandom_range(1, 9999);
         endcase
         mo  = $urandom_range(1, 12);
         cap = days_of(yr, mo);
         case ($urandom_range(0, 11))
            0:       dy = (cap == 31) ? 0 : $urandom_range(cap + 1, 31);
            1, 2, 3: dy = cap;
            default: dy = $urandom_range(1, cap);
         endcase
         case ($urandom_range(0, 3))
            0: amount = $urandom_range(0, 40);
            1: begin
               case (kind)
                  KindDays:   amount = $urandom_range(0, 1500);
                  KindMonths: amount = $urandom_range(0, 2000);
                  default:    amount = $urandom_range(0, yr + 5);
               endcase
            end
            2: amount = $urandom_range(0, 65535);
            default: begin
               // weeks, decades, centuries, millennia
               case ($urandom_range(0, 3))
                  0:       mult = 7;
                  1:       mult = 10;
                  2:       mult = 100;
                  default: mult = 1000;
               endcase
               amount = mult * $urandom_range(0, 65535 / mult);
            end
         endcase
         w = pack_request(kind, amount, yr, mo, dy);
      end
      return w;
   endfunction

   // Present one word and hold it until the block takes it
   task automatic send_word(input req_type w);
      req_data <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // With a chance of pct percent, drop start for a random gap with noise on the data lines
   task automatic rest_sender(input int unsigned pct);
      int unsigned                gap;
      logic [63:0]                raw;
      logic [$bits(req_type)-1:0] noise;
      if ($urandom_range(0, 99) < pct) begin
         gap      = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 320) :
                                                   $urandom_range(1, 24);
         raw      = {$urandom(), $urandom()};
         noise    = raw[$bits(req_type)-1:0];
         start    <= 1'b0;
         req_data <= noise;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      req_type     plan[$];
      int unsigned phase, n, wait_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // edges of the calendar, each kind, bad dates and the unused kind
      plan.push_back(pack_request(KindDays, 0, 2024, 6, 15));
      plan.push_back(pack_request(KindDays, 1, 1, 1, 1));
      plan.push_back(pack_request(KindDays, 1, 1, 1, 2));
      plan.push_back(pack_request(KindDays, 65535, 9999, 12, 31));
      plan.push_back(pack_request(KindDays, 1, 2000, 3, 1));
      plan.push_back(pack_request(KindDays, 1, 1900, 3, 1));
      plan.push_back(pack_request(KindDays, 7 * 52, 2024, 12, 31));
      plan.push_back(pack_request(KindMonths, 1, 2024, 3, 31));
      plan.push_back(pack_request(KindMonths, 1, 2023, 3, 31));
      plan.push_back(pack_request(KindMonths, 12, 2, 1, 15));
      plan.push_back(pack_request(KindMonths, 13, 2, 1, 15));
      plan.push_back(pack_request(KindMonths, 65535, 9999, 12, 31));
      plan.push_back(pack_request(KindYears, 1, 2024, 2, 29));
      plan.push_back(pack_request(KindYears, 4, 2024, 2, 29));
      plan.push_back(pack_request(KindYears, 9998, 9999, 6, 30));
      plan.push_back(pack_request(KindYears, 9999, 9999, 6, 30));
      plan.push_back(pack_request(KindYears, 65535, 2024, 1, 1));
      plan.push_back(pack_request(KindDays, 10, 0, 5, 5));
      plan.push_back(pack_request(KindMonths, 10, 16383, 5, 5));
      plan.push_back(pack_request(KindYears, 10, 2000, 0, 5));
      plan.push_back(pack_request(KindDays, 10, 2000, 15, 5));
      plan.push_back(pack_request(KindMonths, 10, 2000, 5, 0));
      plan.push_back(pack_request(KindYears, 1, 2023, 2, 29));
      plan.push_back(pack_request(KindDays, 1, 2023, 4, 31));
      plan.push_back(pack_request(KindUnused, 500, 1999, 12, 31));
      foreach (plan[i]) send_word(plan[i]);

      // random words over four pacing phases
      for (phase = 0; phase < 4; phase++) begin
         for (n = 0; n < PhaseWords; n++) begin
            send_word(random_request());
            if (!(phase == 3 && n == PhaseWords - 1)) rest_sender(IdlePct[phase]);
         end
      end
      start <= 1'b0;

      // drain outstanding results, then let any late strobe show up
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < DrainLimit) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (TailCycles) @(posedge clock);
      finish_check <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Summary: %0d request words sent, %0d hand-picked and the rest random",
               words_seen, plan.size());
      $display("Summary: %0d result words checked over four sender pacing phases",
               results_seen);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: gregorian_date_subtract.f
sv/gds_pkg.sv
sv/gds_alu.sv
sv/gregorian_date_subtract.sv
sv/gds_checker.sv
bench/date_shift_checker.sv
bench/testbench.sv
